### sv/multi_channel_task_watchdog_top_macros.svh
// Assertion macros shared by the watchdog checker.
// Depends on nothing; every macro samples on the rising edge of clk and idles in rst.
`ifndef MULTI_CHANNEL_TASK_WATCHDOG_TOP_MACROS_SVH
`define MULTI_CHANNEL_TASK_WATCHDOG_TOP_MACROS_SVH

// Same-cycle implication.
`define MCTW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MCTW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/mctw_pkg.sv
// Shared types and constants for the multi-channel task watchdog.
// Used by the controller, the datapath and the top level; depends on nothing.
package mctw_pkg;

  localparam int CHANNELS = 8;
  localparam int CH_W     = 3;
  localparam int CNT_W    = $clog2(CHANNELS + 1);
  localparam int TO_W     = 16;
  localparam int KICK_W   = 8;
  localparam int CFG_W    = 16;
  localparam int CFG_IX_W = 1;

  localparam logic [TO_W-1:0]   STARTUP_RESET = TO_W'(300);
  localparam logic [KICK_W-1:0] KICK_RESET    = KICK_W'(5);

  // Configuration register indexes
  localparam logic [CFG_IX_W-1:0] REG_STARTUP = 1'b0;
  localparam logic [CFG_IX_W-1:0] REG_KICK    = 1'b1;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_FEED  = 2'd1,
    OP_REG   = 2'd2,
    OP_PAUSE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_FULL = 2'd2
  } reg_status_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic step;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic walk_go;
    logic walk_end;
  } dp_sts_t;

endpackage

### sv/mctw_dp.sv
// Datapath of the watchdog: item latch, channel tables, counters and result registers.
// Depends on mctw_pkg; driven by mctw_ctrl through dp_cmd_t.
module mctw_dp import mctw_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CFG_IX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  input  logic [1:0]          opcode,
  input  logic [CH_W-1:0]     channel,
  input  logic [TO_W-1:0]     timeout,
  input  logic                run_flag,
  input  logic                pause_flag,
  input  dp_cmd_t             cmd,
  output dp_sts_t             sts,
  output logic                kick_hw,
  output logic                tripped,
  output logic [CH_W-1:0]     tripped_channel,
  output logic [1:0]          reg_status,
  output logic [CH_W-1:0]     assigned_channel
);

  // Channel tables, no reset (only allocated entries are read)
  logic [TO_W-1:0] reload_value [CHANNELS];
  logic [TO_W-1:0] countdown    [CHANNELS];
  logic [CHANNELS-1:0] running;

  logic [CNT_W-1:0]  allocated_count;
  logic [KICK_W-1:0] kick_counter;
  logic [TO_W-1:0]   startup_counter;
  logic              armed;
  logic              frozen;
  logic [CH_W-1:0]   trip_index;
  logic              paused;
  logic [TO_W-1:0]   startup_ticks;
  logic [KICK_W-1:0] kick_ticks;
  logic [CH_W-1:0]   idx;

  // Latched word
  op_t             op_q;
  logic [CH_W-1:0] ch_q;
  logic [TO_W-1:0] to_q;
  logic            run_q;
  logic            pause_q;

  logic [KICK_W-1:0] kick_inc;
  logic [TO_W-1:0]   startup_inc;
  logic              armed_next;
  logic              feed_ok;
  logic              table_full;
  logic [TO_W-1:0]   cd_cur;
  logic [TO_W-1:0]   cd_dec;
  logic              trip_hit;
  logic              walk_last;

  // Tick preamble and walk status
  always_comb begin
    kick_inc    = kick_counter + KICK_W'(1);
    startup_inc = startup_counter + TO_W'(1);
    armed_next  = armed | (startup_inc >= startup_ticks);
    feed_ok     = {1'b0, ch_q} < allocated_count;
    table_full  = allocated_count >= CNT_W'(CHANNELS);
    cd_cur      = countdown[idx];
    cd_dec      = cd_cur - TO_W'(1);
    trip_hit    = running[idx] && (cd_cur == TO_W'(1));
    walk_last   = ({1'b0, idx} + CNT_W'(1)) == allocated_count;
    sts.walk_go = (op_q == OP_TICK) && !frozen && armed_next && !paused &&
                  (allocated_count != '0);
    sts.walk_end = trip_hit || walk_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      allocated_count <= '0;
      kick_counter    <= '0;
      startup_counter <= '0;
      armed           <= 1'b0;
      frozen          <= 1'b0;
      trip_index      <= '0;
      paused          <= 1'b0;
      startup_ticks   <= STARTUP_RESET;
      kick_ticks      <= KICK_RESET;
      idx             <= '0;
    end else begin
      // Configuration writes
      if (cfg_we) begin
        case (cfg_index)
          REG_STARTUP: startup_ticks <= cfg_data[TO_W-1:0];
          REG_KICK:    kick_ticks    <= cfg_data[KICK_W-1:0];
          default: ;
        endcase
      end

      // Take the word
      if (cmd.load) begin
        op_q    <= op_t'(opcode);
        ch_q    <= channel;
        to_q    <= timeout;
        run_q   <= run_flag;
        pause_q <= pause_flag;
      end

      // Execute the word
      if (cmd.exec) begin
        idx              <= '0;
        kick_hw          <= 1'b0;
        reg_status       <= ST_OK;
        assigned_channel <= '0;
        case (op_q)
          OP_TICK: begin
            if (!frozen) begin
              armed <= armed_next;
              if (!armed) startup_counter <= startup_inc;
              if (sts.walk_go) begin
                kick_counter <= kick_inc;
              end else if (kick_inc >= kick_ticks) begin
                kick_hw      <= 1'b1;
                kick_counter <= '0;
              end else begin
                kick_counter <= kick_inc;
              end
            end
          end
          OP_FEED: begin
            if (feed_ok) countdown[ch_q] <= reload_value[ch_q];
          end
          OP_REG: begin
            if (to_q == '0) begin
              reg_status <= ST_ZERO;
            end else if (table_full) begin
              reg_status <= ST_FULL;
            end else begin
              running[allocated_count[CH_W-1:0]]      <= run_q;
              countdown[allocated_count[CH_W-1:0]]    <= to_q;
              reload_value[allocated_count[CH_W-1:0]] <= to_q;
              allocated_count  <= allocated_count + CNT_W'(1);
              assigned_channel <= allocated_count[CH_W-1:0];
            end
          end
          OP_PAUSE: paused <= pause_q;
          default: ;
        endcase
      end

      // One channel per cycle through the shared decrementer
      if (cmd.step) begin
        if (running[idx]) countdown[idx] <= cd_dec;
        if (trip_hit) begin
          frozen     <= 1'b1;
          trip_index <= idx;
        end else if (walk_last && (kick_counter >= kick_ticks)) begin
          kick_hw      <= 1'b1;
          kick_counter <= '0;
        end
        idx <= idx + CH_W'(1);
      end
    end
  end

  assign tripped         = frozen;
  assign tripped_channel = trip_index;

endmodule

### sv/mctw_ctrl.sv
// Controller of the watchdog: sequences execute and channel walk, raises done.
// Depends on mctw_pkg; commands mctw_dp through dp_cmd_t.
module mctw_ctrl import mctw_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  dp_sts_t sts,
  output dp_cmd_t cmd,
  output logic    busy,
  output logic    done
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WALK
  } state_t;

  state_t state;

  // Commands
  always_comb begin
    cmd.load = start && (state == S_IDLE);
    cmd.exec = (state == S_EXEC);
    cmd.step = (state == S_WALK);
    busy     = (state != S_IDLE);
  end

  // State and done strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) state <= S_EXEC;
        end
        S_EXEC: begin
          if (sts.walk_go) begin
            state <= S_WALK;
          end else begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        S_WALK: begin
          if (sts.walk_end) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### sv/multi_channel_task_watchdog_top.sv
// Multi-channel task watchdog: a word is taken when start is high and busy is low,
// and its one result shows for a single cycle with done high; the receiver cannot
// stall it. Feed, register and pause words finish in the execute state; so does a
// tick, unless monitoring is armed and neither paused nor tripped, with channels
// allocated: then one shared decrementer walks the allocated channels (up to 8)
// one per cycle and stops early at the first one that trips.
// A new word may be started in the cycle done is high. Config writes act at once.
// Top level; depends on mctw_pkg, mctw_ctrl and mctw_dp.
module multi_channel_task_watchdog_top import mctw_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  output logic                done,
  input  logic                cfg_we,
  input  logic [CFG_IX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  input  logic [1:0]          opcode,
  input  logic [CH_W-1:0]     channel,
  input  logic [TO_W-1:0]     timeout,
  input  logic                run_flag,
  input  logic                pause_flag,
  output logic                kick_hw,
  output logic                tripped,
  output logic [CH_W-1:0]     tripped_channel,
  output logic [1:0]          reg_status,
  output logic [CH_W-1:0]     assigned_channel
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  mctw_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  mctw_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .opcode           (opcode),
    .channel          (channel),
    .timeout          (timeout),
    .run_flag         (run_flag),
    .pause_flag       (pause_flag),
    .cmd              (cmd),
    .sts              (sts),
    .kick_hw          (kick_hw),
    .tripped          (tripped),
    .tripped_channel  (tripped_channel),
    .reg_status       (reg_status),
    .assigned_channel (assigned_channel)
  );

endmodule

### sv/mctw_checker.sv
// Port-level checker for the watchdog top level, bound in below.
// Depends on mctw_pkg and multi_channel_task_watchdog_top_macros.svh.
`include "multi_channel_task_watchdog_top_macros.svh"

module mctw_checker import mctw_pkg::*; (
  input logic            clk,
  input logic            rst,
  input logic            start,
  input logic            busy,
  input logic            done,
  input logic            kick_hw,
  input logic            tripped,
  input logic [1:0]      reg_status,
  input logic [CH_W-1:0] assigned_channel
);

  // Done frees the block in the same cycle
  `MCTW_ASSERT_NOW(a_done_not_busy, done, !busy, "done while busy")

  // An accepted word keeps the block busy
  `MCTW_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done, "accept not followed by busy")

  // A trip holds until reset
  `MCTW_ASSERT_NEXT(a_trip_sticky, tripped, tripped, "trip cleared without reset")

  // No kick once tripped
  `MCTW_ASSERT_NOW(a_no_kick_tripped, done && kick_hw, !tripped, "kick after trip")

  // Failed register gives channel zero
  `MCTW_ASSERT_NOW(a_fail_no_channel, done && (reg_status != ST_OK), assigned_channel == '0,
    "channel given on failed register")

endmodule

bind multi_channel_task_watchdog_top mctw_checker u_mctw_checker (
  .clk              (clk),
  .rst              (rst),
  .start            (start),
  .busy             (busy),
  .done             (done),
  .kick_hw          (kick_hw),
  .tripped          (tripped),
  .reg_status       (reg_status),
  .assigned_channel (assigned_channel)
);

### tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for the multi-channel task watchdog top level.
// Depends on mctw_pkg and multi_channel_task_watchdog_top; predicts every result word.
module testbench import mctw_pkg::*; ();

  localparam int CYCLE_LIMIT = 200000;

  // One command word as the block sees it
  typedef struct packed {
    op_t             op;
    logic [CH_W-1:0] ch;
    logic [TO_W-1:0] timeout;
    logic            run;
    logic            pause;
  } wd_word_t;

  // One result word
  typedef struct packed {
    logic            kick;
    logic            trip;
    logic [CH_W-1:0] trip_ch;
    reg_status_t     status;
    logic [CH_W-1:0] slot;
  } wd_result_t;

  // Supervisor state plus its two config registers
  typedef struct packed {
    logic [CHANNELS-1:0][TO_W-1:0] reload;
    logic [CHANNELS-1:0][TO_W-1:0] count;
    logic [CHANNELS-1:0]           run;
    logic [CNT_W-1:0]              n_alloc;
    logic [KICK_W-1:0]             kick_cnt;
    logic [TO_W-1:0]               start_cnt;
    logic                          armed;
    logic                          frozen;
    logic [CH_W-1:0]               trip_ch;
    logic                          paused;
    logic [TO_W-1:0]               startup_ticks;
    logic [KICK_W-1:0]             kick_ticks;
  } wd_state_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic                done;
  logic                cfg_we = 1'b0;
  logic [CFG_IX_W-1:0] cfg_index = REG_STARTUP;
  logic [CFG_W-1:0]    cfg_data = '0;
  logic [1:0]          opcode = OP_TICK;
  logic [CH_W-1:0]     channel = '0;
  logic [TO_W-1:0]     timeout = '0;
  logic                run_flag = 1'b0;
  logic                pause_flag = 1'b0;
  logic                kick_hw;
  logic                tripped;
  logic [CH_W-1:0]     tripped_channel;
  logic [1:0]          reg_status;
  logic [CH_W-1:0]     assigned_channel;

  wd_state_t  model_wd;      // advanced as words are accepted
  wd_state_t  plan_wd;       // advanced as words are queued, used to steer stimulus
  wd_word_t   pending_words[$];
  wd_result_t due_results[$];
  wd_word_t   cur_word;
  wd_result_t next_due;
  wd_result_t got;
  wd_result_t want;
  int         burst_left = 0;
  int         gap_left = 0;
  int         fail_count = 0;
  int         cycle_count = 0;

  multi_channel_task_watchdog_top u_top (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .done             (done),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .opcode           (opcode),
    .channel          (channel),
    .timeout          (timeout),
    .run_flag         (run_flag),
    .pause_flag       (pause_flag),
    .kick_hw          (kick_hw),
    .tripped          (tripped),
    .tripped_channel  (tripped_channel),
    .reg_status       (reg_status),
    .assigned_channel (assigned_channel)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Advance the supervisor by one word and return the word it answers with
  function automatic wd_result_t watchdog_step(inout wd_state_t s, input wd_word_t w);
    wd_result_t r;
    bit         hit;
    int         i;
    int         slot;
    r = '0;
    r.status = ST_OK;
    hit = 1'b0;
    case (w.op)
      OP_TICK: begin
        if (!s.frozen) begin
          s.kick_cnt = s.kick_cnt + 1'b1;
          if (!s.armed) begin
            s.start_cnt = s.start_cnt + 1'b1;
            if (s.start_cnt >= s.startup_ticks) s.armed = 1'b1;
          end
          // walk running channels in index order, first to hit zero trips
          if (s.armed && !s.paused) begin
            for (i = 0; i < CHANNELS; i++) begin
              if (!hit && i < int'(s.n_alloc) && s.run[i]) begin
                s.count[i] = s.count[i] - 1'b1;
                if (s.count[i] == '0) begin
                  s.frozen = 1'b1;
                  s.trip_ch = CH_W'(i);
                  hit = 1'b1;
                end
              end
            end
          end
          if (!hit && s.kick_cnt >= s.kick_ticks) begin
            s.kick_cnt = '0;
            r.kick = 1'b1;
          end
        end
      end
      OP_FEED: begin
        if (CNT_W'(w.ch) < s.n_alloc) s.count[w.ch] = s.reload[w.ch];
      end
      OP_REG: begin
        // zero timeout is reported ahead of a full table
        if (w.timeout == '0) begin
          r.status = ST_ZERO;
        end else if (int'(s.n_alloc) >= CHANNELS) begin
          r.status = ST_FULL;
        end else begin
          slot = int'(s.n_alloc);
          s.run[slot] = w.run;
          s.count[slot] = w.timeout;
          s.reload[slot] = w.timeout;
          s.n_alloc = s.n_alloc + 1'b1;
          r.slot = CH_W'(slot);
        end
      end
      default: begin
        s.paused = w.pause;
      end
    endcase
    r.trip = s.frozen;
    r.trip_ch = s.trip_ch;
    return r;
  endfunction

  function automatic wd_word_t mk_word(op_t op, int ch, int to, int run, int pause);
    wd_word_t w;
    w.op = op;
    w.ch = CH_W'(ch);
    w.timeout = TO_W'(to);
    w.run = 1'(run);
    w.pause = 1'(pause);
    return w;
  endfunction

  task automatic queue_word(input wd_word_t w);
    void'(watchdog_step(plan_wd, w));
    pending_words.push_back(w);
  endtask

  // Random words; with steer set, ticks that would trip become feeds or a pause
  task automatic queue_random(input int n, input bit steer);
    wd_word_t   w;
    wd_state_t  trial;
    int         pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      w.op = (pick < 45) ? OP_TICK : (pick < 75) ? OP_FEED : (pick < 85) ? OP_REG : OP_PAUSE;
      w.ch = CH_W'($urandom_range(0, 7));
      case ($urandom_range(0, 3))
        0:       w.timeout = '0;
        1:       w.timeout = TO_W'($urandom_range(1, 16));
        default: w.timeout = TO_W'($urandom_range(0, 65535));
      endcase
      w.run = 1'($urandom_range(0, 1));
      w.pause = ($urandom_range(0, 9) < 3);
      if (steer && w.op == OP_TICK) begin
        trial = plan_wd;
        void'(watchdog_step(trial, w));
        if (trial.frozen && !plan_wd.frozen) begin
          if (plan_wd.reload[trial.trip_ch] > 1) begin
            w.op = OP_FEED;
            w.ch = trial.trip_ch;
          end else begin
            w.op = OP_PAUSE;
            w.pause = 1'b1;
          end
        end
      end
      queue_word(w);
    end
  endtask

  // Register write; only issued while nothing is in flight
  task automatic write_cfg(input logic [CFG_IX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == REG_STARTUP) begin
      model_wd.startup_ticks = val;
      plan_wd.startup_ticks = val;
    end else begin
      model_wd.kick_ticks = val[KICK_W-1:0];
      plan_wd.kick_ticks = val[KICK_W-1:0];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending_words.size() != 0 || start || due_results.size() != 0) @(negedge clk);
  endtask

  // Driver: bursts of words with random gaps, start held across back-to-back words
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        next_due = watchdog_step(model_wd, cur_word);
        due_results.push_back(next_due);
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_words.size() != 0) begin
          cur_word = pending_words.pop_front();
          opcode <= cur_word.op;
          channel <= cur_word.ch;
          timeout <= cur_word.timeout;
          run_flag <= cur_word.run;
          pause_flag <= cur_word.pause;
          start <= 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: each done cycle carries one result word
  always @(posedge clk) begin
    if (!rst && done) begin
      got = {kick_hw, tripped, tripped_channel, reg_status, assigned_channel};
      if (due_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result word: kick %0d trip %0d ch %0d status %0d slot %0d",
                   got.kick, got.trip, got.trip_ch, got.status, got.slot);
      end else begin
        want = due_results.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: kick %0d/%0d trip %0d/%0d ch %0d/%0d status %0d/%0d slot %0d/%0d",
                     want.kick, got.kick, want.trip, got.trip, want.trip_ch, got.trip_ch,
                     want.status, got.status, want.slot, got.slot);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("multi_channel_task_watchdog_top test failed");
      $finish;
    end
  end

  initial begin
    model_wd = '0;
    model_wd.startup_ticks = STARTUP_RESET;
    model_wd.kick_ticks = KICK_RESET;
    plan_wd = model_wd;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset config: fill the table, hit both register errors, unallocated feed, pause
    queue_word(mk_word(OP_TICK, 0, 0, 0, 0));
    queue_word(mk_word(OP_REG, 0, 0, 1, 0));
    queue_word(mk_word(OP_REG, 0, 16'hFFFF, 1, 0));
    queue_word(mk_word(OP_FEED, 7, 0, 0, 0));
    queue_word(mk_word(OP_REG, 0, 1, 0, 0));
    queue_word(mk_word(OP_REG, 0, 3, 1, 0));
    queue_word(mk_word(OP_REG, 0, 16'h8000, 1, 0));
    queue_word(mk_word(OP_REG, 0, 2, 1, 0));
    queue_word(mk_word(OP_REG, 0, 2, 1, 0));
    queue_word(mk_word(OP_REG, 0, 16'h1234, 1, 0));
    queue_word(mk_word(OP_REG, 0, 7, 0, 0));
    queue_word(mk_word(OP_REG, 0, 9, 1, 0));
    queue_word(mk_word(OP_REG, 0, 0, 0, 0));
    queue_word(mk_word(OP_FEED, 0, 0, 0, 0));
    queue_word(mk_word(OP_PAUSE, 0, 0, 0, 1));
    queue_word(mk_word(OP_TICK, 0, 0, 0, 0));
    queue_word(mk_word(OP_PAUSE, 0, 0, 0, 0));
    repeat (5) queue_word(mk_word(OP_TICK, 0, 0, 0, 0));
    wait_idle();

    // Longest startup and kick interval, still unarmed
    write_cfg(REG_STARTUP, 16'hFFFF);
    write_cfg(REG_KICK, {8'($urandom), 8'd255});
    queue_random(20, 1'b1);
    wait_idle();

    // Zero startup arms on the next tick, zero kick interval kicks every tick
    write_cfg(REG_STARTUP, '0);
    write_cfg(REG_KICK, {8'($urandom), 8'd0});
    queue_word(mk_word(OP_TICK, 0, 0, 0, 0));
    queue_random(25, 1'b1);
    wait_idle();

    // Armed phases under assorted kick intervals
    for (int p = 0; p < 7; p++) begin
      write_cfg(REG_STARTUP, CFG_W'($urandom_range(0, 65535)));
      case (p)
        0:       write_cfg(REG_KICK, {8'($urandom), 8'd1});
        1:       write_cfg(REG_KICK, {8'($urandom), 8'd255});
        default: write_cfg(REG_KICK, {8'($urandom),
                           8'($urandom_range(0, 1) ? $urandom_range(1, 8)
                                                   : $urandom_range(1, 255))});
      endcase
      queue_random(125, 1'b1);
      wait_idle();
    end

    // Two channels expire on the same tick, the lower index is reported; then frozen
    write_cfg(REG_KICK, {8'($urandom), 8'd3});
    queue_word(mk_word(OP_PAUSE, 0, 0, 0, 0));
    for (int c = 0; c < CHANNELS; c++) queue_word(mk_word(OP_FEED, c, 0, 0, 0));
    queue_word(mk_word(OP_TICK, 0, 0, 0, 0));
    queue_word(mk_word(OP_FEED, 2, 0, 0, 0));
    queue_word(mk_word(OP_TICK, 0, 0, 0, 0));
    queue_word(mk_word(OP_TICK, 0, 0, 0, 0));
    queue_word(mk_word(OP_FEED, 4, 0, 0, 0));
    queue_word(mk_word(OP_REG, 0, 5, 1, 0));
    queue_word(mk_word(OP_PAUSE, 0, 0, 0, 1));
    queue_random(25, 1'b0);
    wait_idle();

    repeat (12) @(posedge clk);
    fail_count += due_results.size();
    if (fail_count == 0) begin
      $display("multi_channel_task_watchdog_top test passed");
    end else begin
      $display("multi_channel_task_watchdog_top test failed");
    end
    $finish;
  end

endmodule
